>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; the macros expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/ictf_pkg.sv
// constants and helper functions for the complementary tilt filter
// no dependencies
package ictf_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CIW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

  localparam logic signed [33:0] DEG180_Q16 = 34'sd11796480;
  localparam logic signed [33:0] DEG360_Q16 = 34'sd23592960;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [31:0] GAIN_RESET = 32'd327680;
  localparam logic [16:0] WEIGHT_RESET = 17'd62259;

  localparam logic CFG_GAIN = 1'b0;
  localparam logic CFG_WEIGHT = 1'b1;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [31:0] atan_q16(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0: v = 32'd2949120;
      5'd1: v = 32'd1740967;
      5'd2: v = 32'd919879;
      5'd3: v = 32'd466945;
      5'd4: v = 32'd234379;
      5'd5: v = 32'd117304;
      5'd6: v = 32'd58666;
      5'd7: v = 32'd29335;
      5'd8: v = 32'd14668;
      5'd9: v = 32'd7334;
      5'd10: v = 32'd3667;
      5'd11: v = 32'd1833;
      5'd12: v = 32'd917;
      5'd13: v = 32'd458;
      5'd14: v = 32'd229;
      5'd15: v = 32'd115;
      5'd16: v = 32'd57;
      5'd17: v = 32'd29;
      5'd18: v = 32'd14;
      5'd19: v = 32'd7;
      5'd20: v = 32'd4;
      5'd21: v = 32'd2;
      5'd22: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/imu_complementary_tilt_filter.sv
// complementary roll/pitch/yaw filter, top level
// depends on ictf_pkg and assert_macros.svh
//
// One IMU sample per input word gives one word of roll, pitch and yaw (Q16.16
// degrees). The block works on one sample at a time. It uses a single shared
// 35x18 multiplier, a bit-serial square root and one CORDIC rotator that runs
// twice (accel roll, then accel pitch). A sample passes from its accept through
// 6 multiplier steps, 32 root steps, two CORDIC passes of one setup plus
// CORDIC_ITERATIONS steps, 5 blend steps and one commit, then back to idle. A
// zero accel vector skips the CORDIC_ITERATIONS steps of its pass. The commit
// waits while an earlier result is still held by out_tready low. in_tready is
// high only while idle. The result sits in an output register, so a new sample
// may be taken while the last result waits.
`include "assert_macros.svh"
module imu_complementary_tilt_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // roll_angle, pitch_angle, yaw_angle (32 bits each)
  output logic [95:0] out_tdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_CSET  = 3'd3;
  localparam logic [2:0] ST_CORD  = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam int CIW = ictf_pkg::CIW;

  logic [2:0] st_r, st_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [CIW-1:0] ci_r, ci_nxt;
  logic pass_r, pass_nxt;

  logic [31:0] gain_r;
  logic [16:0] weight_r;

  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic signed [31:0] roll_est_r, roll_est_nxt;
  logic signed [31:0] pitch_est_r, pitch_est_nxt;
  logic signed [31:0] yaw_est_r, yaw_est_nxt;
  logic signed [33:0] g_roll_r, g_roll_nxt, g_pitch_r, g_pitch_nxt, g_yaw_r, g_yaw_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic signed [35:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [33:0] cz_r, cz_nxt;
  logic signed [33:0] a_roll_r, a_roll_nxt, a_pitch_r, a_pitch_nxt;
  logic signed [52:0] mul_r, acc_r, acc_nxt;
  logic signed [34:0] op_a;
  logic signed [17:0] op_b;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [95:0] out_tdata_r, out_tdata_nxt;

  // weights
  logic [16:0] w_sat, w_acc;
  assign w_sat = (weight_r > ictf_pkg::ONE_Q16) ? ictf_pkg::ONE_Q16 : weight_r;
  assign w_acc = ictf_pkg::ONE_Q16 - w_sat;

  // rounded gyro increment from the product register
  logic signed [52:0] inc_sum;
  logic signed [33:0] inc;
  assign inc_sum = mul_r + 53'sd32768;
  assign inc = 34'(signed'(inc_sum[48:16]));

  // blend sum
  logic signed [53:0] bl_sum;
  logic signed [31:0] bl_res;
  assign bl_sum = 54'(acc_r) + 54'(mul_r) + 54'sd32768;
  assign bl_res = ictf_pkg::sat32(40'(signed'(bl_sum[53:16])));

  // yaw wrap
  logic signed [34:0] yaw_w;
  always_comb begin
    if (g_yaw_r > ictf_pkg::DEG180_Q16) begin
      yaw_w = 35'(g_yaw_r) - 35'(ictf_pkg::DEG360_Q16);
    end else if (g_yaw_r < -ictf_pkg::DEG180_Q16) begin
      yaw_w = 35'(g_yaw_r) + 35'(ictf_pkg::DEG360_Q16);
    end else begin
      yaw_w = 35'(g_yaw_r);
    end
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (st_r == ST_MUL) begin
      unique case (cnt_r)
        5'd0: begin op_a = 35'({1'b0, gain_r}); op_b = 18'(gx_r); end
        5'd1: begin op_a = 35'({1'b0, gain_r}); op_b = 18'(gy_r); end
        5'd2: begin op_a = 35'({1'b0, gain_r}); op_b = 18'(gz_r); end
        5'd3: begin op_a = 35'(ax_r); op_b = 18'(ax_r); end
        5'd4: begin op_a = 35'(az_r); op_b = 18'(az_r); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (st_r == ST_BLEND) begin
      unique case (cnt_r)
        5'd0: begin op_a = 35'(g_roll_r); op_b = 18'({1'b0, w_sat}); end
        5'd1: begin op_a = 35'(a_roll_r); op_b = 18'({1'b0, w_acc}); end
        5'd2: begin op_a = 35'(g_pitch_r); op_b = 18'({1'b0, w_sat}); end
        5'd3: begin op_a = 35'(a_pitch_r); op_b = 18'({1'b0, w_acc}); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  // square root step
  logic [35:0] rem_sh, trial;
  assign rem_sh = {rem_r[33:0], rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  // cordic setup operands
  logic signed [35:0] x0, y0;
  logic zero_vec;
  always_comb begin
    if (!pass_r) begin
      y0 = -(36'(ax_r) <<< 16);
      x0 = 36'(az_r) <<< 16;
      zero_vec = (ax_r == '0) && (az_r == '0);
    end else begin
      y0 = 36'(ay_r) <<< 16;
      x0 = signed'({4'b0000, root_r});
      zero_vec = (ay_r == '0) && (root_r == '0);
    end
  end

  // cordic micro-rotation
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  assign xs = cx_r >>> ci_r;
  assign ys = cy_r >>> ci_r;
  assign at = signed'({2'b00, ictf_pkg::atan_q16(5'(ci_r))});

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    ci_nxt = ci_r;
    pass_nxt = pass_r;
    roll_est_nxt = roll_est_r;
    pitch_est_nxt = pitch_est_r;
    yaw_est_nxt = yaw_est_r;
    g_roll_nxt = g_roll_r;
    g_pitch_nxt = g_pitch_r;
    g_yaw_nxt = g_yaw_r;
    sq_nxt = sq_r;
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    a_roll_nxt = a_roll_r;
    a_pitch_nxt = a_pitch_r;
    acc_nxt = acc_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          st_nxt = ST_MUL;
          cnt_nxt = '0;
        end
      end
      ST_MUL: begin
        // product of step n is registered in mul_r and used at step n+1
        unique case (cnt_r)
          5'd1: g_roll_nxt = 34'(roll_est_r) + inc;
          5'd2: g_pitch_nxt = 34'(pitch_est_r) + inc;
          5'd3: g_yaw_nxt = 34'(yaw_est_r) + inc;
          5'd4: sq_nxt = mul_r[31:0];
          5'd5: begin
            rad_nxt = {sq_r + mul_r[31:0], 32'd0};
            rem_nxt = '0;
            root_nxt = '0;
          end
          default: ;
        endcase
        if (cnt_r == 5'd5) begin
          st_nxt = ST_SQRT;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_SQRT: begin
        rad_nxt = {rad_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          root_nxt = {root_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          st_nxt = ST_CSET;
          pass_nxt = 1'b0;
        end
      end
      ST_CSET: begin
        ci_nxt = '0;
        if (zero_vec) begin
          if (!pass_r) begin
            a_roll_nxt = '0;
            pass_nxt = 1'b1;
          end else begin
            a_pitch_nxt = '0;
            st_nxt = ST_BLEND;
            cnt_nxt = '0;
          end
        end else begin
          st_nxt = ST_CORD;
          // fold the left half-plane
          if (x0 < 0) begin
            cz_nxt = (y0 >= 0) ? ictf_pkg::DEG180_Q16 : -ictf_pkg::DEG180_Q16;
            cx_nxt = -x0;
            cy_nxt = -y0;
          end else begin
            cz_nxt = '0;
            cx_nxt = x0;
            cy_nxt = y0;
          end
        end
      end
      ST_CORD: begin
        if (cy_r >= 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + at;
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - at;
        end
        ci_nxt = ci_r + 1'b1;
        if (ci_r == CIW'(ictf_pkg::CORDIC_ITERATIONS - 1)) begin
          if (!pass_r) begin
            a_roll_nxt = cz_nxt;
            pass_nxt = 1'b1;
            st_nxt = ST_CSET;
          end else begin
            a_pitch_nxt = cz_nxt;
            st_nxt = ST_BLEND;
            cnt_nxt = '0;
          end
        end
      end
      ST_BLEND: begin
        unique case (cnt_r)
          5'd1: acc_nxt = mul_r;
          5'd2: roll_est_nxt = bl_res;
          5'd3: acc_nxt = mul_r;
          5'd4: pitch_est_nxt = bl_res;
          default: ;
        endcase
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd4) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          yaw_est_nxt = ictf_pkg::sat32(40'(yaw_w));
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt = {ictf_pkg::sat32(40'(yaw_w)), pitch_est_r, roll_est_r};
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      ci_r <= '0;
      pass_r <= 1'b0;
      gain_r <= ictf_pkg::GAIN_RESET;
      weight_r <= ictf_pkg::WEIGHT_RESET;
      roll_est_r <= '0;
      pitch_est_r <= '0;
      yaw_est_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ci_r <= ci_nxt;
      pass_r <= pass_nxt;
      roll_est_r <= roll_est_nxt;
      pitch_est_r <= pitch_est_nxt;
      yaw_est_r <= yaw_est_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          ictf_pkg::CFG_GAIN: gain_r <= cfg_wdata;
          ictf_pkg::CFG_WEIGHT: weight_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_tvalid) begin
      ax_r <= in_tdata[15:0];
      ay_r <= in_tdata[31:16];
      az_r <= in_tdata[47:32];
      gx_r <= in_tdata[63:48];
      gy_r <= in_tdata[79:64];
      gz_r <= in_tdata[95:80];
    end
    mul_r <= 53'(op_a * op_b);
    g_roll_r <= g_roll_nxt;
    g_pitch_r <= g_pitch_nxt;
    g_yaw_r <= g_yaw_nxt;
    sq_r <= sq_nxt;
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    a_roll_r <= a_roll_nxt;
    a_pitch_r <= a_pitch_nxt;
    acc_r <= acc_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;

  `ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, st_r == ST_MUL && cnt_r == 5'd0, "no start")
  `ASSERT_IMPL(a_weight_cap, 1'b1, w_sat + w_acc == ictf_pkg::ONE_Q16, "weights do not sum to one")
  `ASSERT_NEXT(a_done_loads, st_r == ST_DONE && (!out_tvalid || out_tready), out_tvalid, "no load")
  `ASSERT_IMPL(a_busy_blocks, st_r != ST_IDLE, !in_tready, "input taken while busy")

endmodule

>>> sim/tb_top.sv
// self-checking testbench for imu_complementary_tilt_filter
// depends on ictf_pkg and the rtl; the tilt predictor below tracks roll, pitch, yaw and registers
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] gz, gy, gx, az, ay, ax;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] yaw, pitch, roll;
  } tilt_t;

  typedef struct {
    imu_sample_t s;
    bit          typed;
    tilt_t       want;
  } stim_row_t;

  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint FULL_TURN = 64'sd23592960;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = ictf_pkg::CFG_GAIN;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  imu_complementary_tilt_filter uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0]        step_gain;
  logic [16:0]        fuse_weight;
  logic signed [31:0] roll_est, pitch_est, yaw_est;

  tilt_t tilt_q[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z = 0;
    longint xs, ys;
    if (x == 0 && y == 0) return 0;
    // fold left half-plane
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ictf_pkg::CORDIC_ITERATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ictf_pkg::atan_q16(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(ictf_pkg::atan_q16(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rate_step(logic signed [15:0] raw);
    longint p = longint'(raw) * longint'({32'd0, step_gain});
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint fuse(longint g, longint a, longint w);
    return clamp32((g * w + a * (65536 - w) + 32768) >>> 16);
  endfunction

  function automatic tilt_t predict_tilt(imu_sample_t s);
    tilt_t r;
    longint ax = s.ax, ay = s.ay, az = s.az;
    longint w = (fuse_weight > 17'd65536) ? 65536 : longint'(fuse_weight);
    longint g_roll = longint'(roll_est) + rate_step(s.gx);
    longint g_pitch = longint'(pitch_est) + rate_step(s.gy);
    longint g_yaw = longint'(yaw_est) + rate_step(s.gz);
    longint unsigned sq = longint'(ax * ax + az * az);
    longint horiz = longint'(root64(sq << 32));
    longint a_roll = vec_angle(-ax * 65536, az * 65536);
    longint a_pitch = vec_angle(ay * 65536, horiz);
    roll_est = 32'(fuse(g_roll, a_roll, w));
    pitch_est = 32'(fuse(g_pitch, a_pitch, w));
    if (g_yaw > HALF_TURN) g_yaw -= FULL_TURN;
    else if (g_yaw < -HALF_TURN) g_yaw += FULL_TURN;
    yaw_est = 32'(clamp32(g_yaw));
    r.roll = roll_est;
    r.pitch = pitch_est;
    r.yaw = yaw_est;
    return r;
  endfunction

  task automatic send_sample(imu_sample_t s, bit typed, tilt_t want);
    tilt_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = s;
    do @(posedge clk); while (!in_tready);
    p = predict_tilt(s);
    tilt_q.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (tilt_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic addr, logic [31:0] data);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == ictf_pkg::CFG_GAIN) step_gain = data;
    else fuse_weight = data[16:0];
  endtask

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    if ($urandom_range(2) == 0) begin
      s = {$urandom, $urandom, $urandom};
      if ($urandom_range(5) == 0) s.ax = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
      if ($urandom_range(5) == 0) s.az = 16'sd0;
    end else begin
      // plausible motion: gravity plus noise, modest rates
      s.ax = $signed(16'($urandom_range(8000))) - 16'sd4000;
      s.ay = $signed(16'($urandom_range(8000))) - 16'sd4000;
      s.az = 16'sd16384 - $signed(16'($urandom_range(4000)));
      s.gx = $signed(16'($urandom_range(2000))) - 16'sd1000;
      s.gy = $signed(16'($urandom_range(2000))) - 16'sd1000;
      s.gz = $signed(16'($urandom_range(20000))) - 16'sd10000;
    end
    return s;
  endfunction

  // receiver stall
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // result check
  always @(posedge clk) begin
    tilt_t got, exp_t;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (tilt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp_t = tilt_q.pop_front();
        if (got !== exp_t) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                     exp_t.roll, got.roll, exp_t.pitch, got.pitch, exp_t.yaw, got.yaw);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    stim_row_t   rows[$];
    int          idle_modes[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{37, 37}};
    logic [31:0] gains[5] = '{ictf_pkg::GAIN_RESET, 32'd0, 32'hFFFF_FFFF, 32'd0,
                              32'd3_000_000};
    logic [31:0] weights[5] = '{32'(ictf_pkg::WEIGHT_RESET), 32'd0, 32'd65536, 32'h1FFFF,
                                32'd32768};
    stim_row_t   r;
    step_gain = ictf_pkg::GAIN_RESET;
    fuse_weight = ictf_pkg::WEIGHT_RESET;
    roll_est = 0; pitch_est = 0; yaw_est = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero vector from reset leaves everything at zero
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '0});
    // ax=0, az<0: accel roll at +180
    rows.push_back('{'{0, 0, 0, 16'sh8000, 0, 0}, 1'b0, '0});
    rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                     1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                     1'b0, '0});
    rows.push_back('{'{0, 0, 0, 0, 0, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{0, 0, 0, 0, 1, 0}, 1'b0, '0});
    rows.push_back('{'{0, 0, 16384, 0, 0, 0}, 1'b0, '0});
    rows.push_back('{'{0, 16384, 16384, 0, 0, 16'hFFFF}, 1'b0, '0});
    rows.push_back('{'{0, 16'shC000, 0, 16'sh8000, 16'sh7FFF, 0}, 1'b0, '0});
    rows.push_back('{'{0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0});
    rows.push_back('{'{16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF, 1}, 1'b0, '0});
    rows.push_back('{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
                     1'b0, '0});
    for (int i = 0; i < rows.size(); i++) begin
      r = rows[i];
      send_sample(r.s, r.typed, r.want);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ictf_pkg::CFG_GAIN, ph == 3 ? $urandom : gains[ph]);
      write_reg(ictf_pkg::CFG_WEIGHT, weights[ph]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = idle_modes[m][0];
        recv_stall_pct = idle_modes[m][1];
        for (int k = 0; k < 27; k++) begin
          send_sample(rand_sample(), 1'b0, '0);
          if (k == 13 && m == 1) drain();
        end
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(negedge clk);
    mismatches += tilt_q.size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
